// ----- design/rgbc_pkg.sv -----
// Shared types and constants for the RGB 3x3 window convolution block.
`timescale 1ns / 1ps
package rgbc_pkg;

  localparam int MaxLineLength = 1024;
  localparam int MaxLines      = 1024;
  localparam int KernelSize    = 3;
  localparam int NumTaps       = KernelSize * KernelSize;
  localparam int CfgW          = 48;
  localparam int GeoW          = 11;
  localparam int ColW          = $clog2(MaxLineLength);
  localparam int PixW          = 24;
  localparam int TapW          = 16;
  localparam int AccW          = 28;
  localparam int MagW          = 27;
  localparam int RemW          = TapW + 1;
  localparam int CntW          = $clog2(MagW);
  localparam int OffW          = 11;

  typedef logic [PixW-1:0] pix_t;

  typedef enum logic [2:0] {
    CFG_KROW0   = 3'd0,
    CFG_KROW1   = 3'd1,
    CFG_KROW2   = 3'd2,
    CFG_DIVISOR = 3'd3,
    CFG_OFFSET  = 3'd4,
    CFG_LINELEN = 3'd5,
    CFG_LINETOT = 3'd6
  } cfg_idx_e;

  // border mask: which window rows / columns lie inside the image
  typedef struct packed {
    logic [KernelSize-1:0] row_ok;
    logic [KernelSize-1:0] col_ok;
  } mask_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

endpackage

// ----- design/rgbc_line_ram.sv -----
// Simple dual-port line store RAM with registered read.
`timescale 1ns / 1ps
module rgbc_line_ram #(
  parameter int Depth = 1024,
  parameter int Width = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- design/rgbc_arith.sv -----
// Tap-serial multiply-accumulate, bit-serial floor divide and clamp for three channels.
`timescale 1ns / 1ps
module rgbc_arith import rgbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                take_i,
  input  pix_t                window_i [NumTaps],
  input  logic [CfgW-1:0]     kernel_i [KernelSize],
  input  logic [TapW-1:0]     divisor_i,
  input  logic [OffW-1:0]     offset_i,
  input  mask_t               mask_i,
  output arith_stat_t         stat_o,
  output logic [7:0]          res_o [3]
);

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_MAC  = 6'b000010,
    A_PREP = 6'b000100,
    A_DIV  = 6'b001000,
    A_FIN  = 6'b010000,
    A_DONE = 6'b100000
  } astate_e;

  astate_e                state_q, state_d;
  logic [1:0]             dl_q, dl_d, dc_q, dc_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [AccW-1:0] acc_q [3];
  logic signed [AccW-1:0] acc_d [3];
  logic [MagW-1:0]        quo_q [3];
  logic [MagW-1:0]        quo_d [3];
  logic [RemW-1:0]        rem_q [3];
  logic [RemW-1:0]        rem_d [3];
  logic [2:0]             neg_q, neg_d;
  logic [7:0]             res_q [3];
  logic [7:0]             res_d [3];

  logic signed [TapW-1:0] tap;
  logic [3:0]             widx;
  logic                   tap_ok;
  logic [TapW-1:0]        dv;

  always_comb begin
    widx   = 4'(dl_q) * 4'd3 + 4'(dc_q);
    tap    = $signed(kernel_i[dc_q][TapW*dl_q +: TapW]);
    tap_ok = mask_i.row_ok[dl_q] & mask_i.col_ok[dc_q];
    dv     = (divisor_i == '0) ? TapW'(1) : divisor_i;
  end

  always_comb begin
    logic signed [TapW+8:0]   prod;
    logic [7:0]               px;
    logic [RemW-1:0]          rsh;
    logic signed [MagW+1:0]   qs;
    logic signed [MagW+2:0]   v;
    state_d = state_q;
    dl_d    = dl_q;
    dc_d    = dc_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    res_d   = res_q;
    prod    = '0;
    px      = '0;
    rsh     = '0;
    qs      = '0;
    v       = '0;
    unique case (state_q)
      A_IDLE: begin
        if (start_i) begin
          state_d = A_MAC;
          dl_d    = '0;
          dc_d    = '0;
          for (int c = 0; c < 3; c++) acc_d[c] = '0;
        end
      end
      A_MAC: begin
        for (int c = 0; c < 3; c++) begin
          px   = window_i[widx][8*(2-c) +: 8];
          prod = tap * $signed({1'b0, px});
          if (tap_ok) acc_d[c] = acc_q[c] + AccW'(prod);
        end
        if (dc_q == 2'd2) begin
          dc_d = '0;
          dl_d = dl_q + 2'd1;
          if (dl_q == 2'd2) state_d = A_PREP;
        end else begin
          dc_d = dc_q + 2'd1;
        end
      end
      A_PREP: begin
        for (int c = 0; c < 3; c++) begin
          neg_d[c] = acc_q[c][AccW-1];
          quo_d[c] = acc_q[c][AccW-1] ? MagW'(-acc_q[c]) : MagW'(acc_q[c]);
          rem_d[c] = '0;
        end
        cnt_d   = CntW'(MagW - 1);
        state_d = A_DIV;
      end
      A_DIV: begin
        for (int c = 0; c < 3; c++) begin
          rsh = {rem_q[c][RemW-2:0], quo_q[c][MagW-1]};
          if (rsh >= {1'b0, dv}) begin
            rem_d[c] = rsh - {1'b0, dv};
            quo_d[c] = {quo_q[c][MagW-2:0], 1'b1};
          end else begin
            rem_d[c] = rsh;
            quo_d[c] = {quo_q[c][MagW-2:0], 1'b0};
          end
        end
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) state_d = A_FIN;
      end
      A_FIN: begin
        for (int c = 0; c < 3; c++) begin
          // floor for negative sums: round the magnitude up
          qs = neg_q[c] ? -$signed({2'b00, quo_q[c]} + (MagW+2)'(rem_q[c] != '0))
                        :  $signed({2'b00, quo_q[c]});
          v  = (MagW+3)'(qs) + (MagW+3)'($signed(offset_i));
          if (v < 0)                    res_d[c] = 8'd0;
          else if (v > (MagW+3)'(255))  res_d[c] = 8'd255;
          else                          res_d[c] = v[7:0];
        end
        state_d = A_DONE;
      end
      A_DONE: begin
        if (take_i) state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      dl_q    <= '0;
      dc_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      dl_q    <= dl_d;
      dc_q    <= dc_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign stat_o.busy = (state_q != A_IDLE);
  assign stat_o.done = (state_q == A_DONE);
  assign res_o       = res_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == A_IDLE) else $error("start while arithmetic busy");
  a_mac_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == A_IDLE && start_i |=> ##8 state_q == A_MAC ##1 state_q == A_PREP)
    else $error("multiply-accumulate did not take nine taps");
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == A_DIV && cnt_q == '0 |=> state_q == A_FIN)
    else $error("divider did not finish");

endmodule

// ----- design/rgb_window_convolution_top.sv -----
// Top level: RGB 3x3 zero-padded window convolution over a pixel stream.
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_stall_o  | command, red_in, green_in, blue_in
//  out     | output    | out_valid_o/out_stall_i| red_out, green_out, blue_out, frame_done
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
// One beat at a time: an emitting item goes through line store read, nine-tap serial MAC,
// 27-step serial divide and clamp; one that emits nothing does only the line store read.
// The line stores are two 1024x24 RAMs, read on accept and written back the cycle after.
// Reset clears positions, window and config registers; the line stores are not cleared.
// The next beat is taken while a result waits on a stalled output.
`timescale 1ns / 1ps
module rgb_window_convolution_top import rgbc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            command_i,
  input  logic [7:0]      red_in_i,
  input  logic [7:0]      green_in_i,
  input  logic [7:0]      blue_in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      red_out_o,
  output logic [7:0]      green_out_o,
  output logic [7:0]      blue_out_o,
  output logic            frame_done_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_CALC = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CfgW-1:0] krow_q [KernelSize];
  logic [TapW-1:0] divisor_q;
  logic [OffW-1:0] offset_q;
  logic [GeoW-1:0] line_len_q, line_tot_q, len, tot;

  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [GeoW-1:0] in_line_q, in_line_d, out_line_q, out_line_d;
  pix_t            win_q [NumTaps];
  pix_t            win_d [NumTaps];
  pix_t            pix_q, rd_a, rd_b;
  mask_t           mask_q, mask_d;
  logic            done_q, done_d;
  logic            in_acc, emit, out_load, ram_we;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_q [3];
  logic [7:0]      res [3];
  arith_stat_t     astat;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    if (line_len_q < GeoW'(4))                  len = GeoW'(4);
    else if (line_len_q > GeoW'(MaxLineLength)) len = GeoW'(MaxLineLength);
    else                                        len = line_len_q;
    if (line_tot_q < GeoW'(4))                  tot = GeoW'(4);
    else if (line_tot_q > GeoW'(MaxLines))      tot = GeoW'(MaxLines);
    else                                        tot = line_tot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      krow_q[0]  <= '0;
      krow_q[1]  <= CfgW'(48'h0000_0100_0000);
      krow_q[2]  <= '0;
      divisor_q  <= TapW'(256);
      offset_q   <= '0;
      line_len_q <= GeoW'(1024);
      line_tot_q <= GeoW'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KROW0:   krow_q[0]  <= cfg_data_i;
        CFG_KROW1:   krow_q[1]  <= cfg_data_i;
        CFG_KROW2:   krow_q[2]  <= cfg_data_i;
        CFG_DIVISOR: divisor_q  <= cfg_data_i[TapW-1:0];
        CFG_OFFSET:  offset_q   <= cfg_data_i[OffW-1:0];
        CFG_LINELEN: line_len_q <= cfg_data_i[GeoW-1:0];
        CFG_LINETOT: line_tot_q <= cfg_data_i[GeoW-1:0];
        default: ;
      endcase
    end
  end

  // bank a holds the newer line, bank b the older one
  assign ram_we = (state_q == ST_RD);

  rgbc_line_ram #(.Depth(MaxLineLength), .Width(PixW)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_col_q),
    .wdata_i (pix_q),
    .re_i    (in_acc),
    .raddr_i (in_col_q),
    .rdata_o (rd_a)
  );

  rgbc_line_ram #(.Depth(MaxLineLength), .Width(PixW)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_col_q),
    .wdata_i (rd_a),
    .re_i    (in_acc),
    .raddr_i (in_col_q),
    .rdata_o (rd_b)
  );

  assign emit = (in_line_q >= GeoW'(2)) || (in_line_q == GeoW'(1) && in_col_q != '0);

  always_comb begin
    state_d     = state_q;
    in_col_d    = in_col_q;
    in_line_d   = in_line_q;
    out_col_d   = out_col_q;
    out_line_d  = out_line_q;
    win_d       = win_q;
    mask_d      = mask_q;
    done_d      = done_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_RD;
      end
      ST_RD: begin
        for (int r = 0; r < KernelSize; r++) begin
          win_d[r*3+0] = win_q[r*3+1];
          win_d[r*3+1] = win_q[r*3+2];
        end
        win_d[2] = rd_b;
        win_d[5] = rd_a;
        win_d[8] = pix_q;
        if ({1'b0, in_col_q} + GeoW'(1) >= len) begin
          in_col_d  = '0;
          in_line_d = in_line_q + GeoW'(1);
        end else begin
          in_col_d  = in_col_q + ColW'(1);
        end
        if (emit) begin
          mask_d.row_ok = {out_line_q + GeoW'(1) < tot, 1'b1, out_line_q != '0};
          mask_d.col_ok = {{1'b0, out_col_q} + GeoW'(1) < len, 1'b1, out_col_q != '0};
          done_d = (out_line_q + GeoW'(1) > tot) ||
                   (out_line_q + GeoW'(1) == tot && {1'b0, out_col_q} + GeoW'(1) >= len);
          if (done_d) begin
            in_col_d   = '0;
            in_line_d  = '0;
            out_col_d  = '0;
            out_line_d = '0;
          end else if ({1'b0, out_col_q} + GeoW'(1) >= len) begin
            out_col_d  = '0;
            out_line_d = out_line_q + GeoW'(1);
          end else begin
            out_col_d  = out_col_q + ColW'(1);
          end
          state_d = ST_CALC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CALC: begin
        if (astat.done && (!out_valid_q || !out_stall_i)) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_col_q    <= '0;
      in_line_q   <= '0;
      out_col_q   <= '0;
      out_line_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumTaps; i++) win_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_line_q   <= in_line_d;
      out_col_q   <= out_col_d;
      out_line_q  <= out_line_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    done_q <= done_d;
    if (in_acc) begin
      pix_q <= (!command_i && in_line_q < tot) ? {red_in_i, green_in_i, blue_in_i} : '0;
    end
    if (out_load) out_q <= res;
  end

  logic frame_done_q;
  always_ff @(posedge clk_i) begin
    if (out_load) frame_done_q <= done_q;
  end

  rgbc_arith u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == ST_RD && emit),
    .take_i    (out_load),
    .window_i  (win_q),
    .kernel_i  (krow_q),
    .divisor_i (divisor_q),
    .offset_i  (offset_q),
    .mask_i    (mask_q),
    .stat_o    (astat),
    .res_o     (res)
  );

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_q[0];
  assign green_out_o  = out_q[1];
  assign blue_out_o   = out_q[2];
  assign frame_done_o = frame_done_q;

  a_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD && !emit |=> state_q == ST_IDLE) else $error("silent beat stuck");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC && astat.done && !out_valid_q |=> out_valid_q)
    else $error("result not loaded");
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD && emit && done_d |=> in_line_q == '0 && out_line_q == '0)
    else $error("positions not cleared at frame end");
  a_calc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |-> astat.busy) else $error("calc without arithmetic");

endmodule

// ----- verif/rgbc_checker.sv -----
// Checker: predicts 3x3 window convolution results and compares output beats.
`timescale 1ns / 1ps
module rgbc_checker import rgbc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic            command_i,
  input  logic [7:0]      red_in_i,
  input  logic [7:0]      green_in_i,
  input  logic [7:0]      blue_in_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic [7:0]      red_out_i,
  input  logic [7:0]      green_out_i,
  input  logic [7:0]      blue_out_i,
  input  logic            frame_done_i,
  output int              fail_count_o,
  output int              pending_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       done;
  } conv_px_t;

  conv_px_t   expected_px_q[$];
  logic [47:0] krow [3];
  logic [15:0] div_q;
  logic [10:0] offs;
  logic [10:0] len_reg, tot_reg;
  pix_t       lines [2*MaxLineLength];
  pix_t       win [NumTaps];
  int         in_ln, in_col, out_ln, out_col;

  assign pending_o = expected_px_q.size();

  function automatic int eff_geo(logic [10:0] v);
    if (v < 4) return 4;
    if (v > 1024) return 1024;
    return int'(v);
  endfunction

  function automatic logic [7:0] conv_chan(int sh, bit [2:0] rok, bit [2:0] cok);
    longint sum, d, q, v;
    logic [15:0] f;
    sum = 0;
    for (int dl = 0; dl < 3; dl++)
      for (int dc = 0; dc < 3; dc++)
        if (rok[dl] && cok[dc]) begin
          f = krow[dc][16*dl +: 16];
          sum += longint'($signed(f)) * longint'((win[dl*3+dc] >> sh) & 8'hff);
        end
    d = (div_q == 0) ? 1 : longint'(div_q);
    if (sum >= 0) q = sum / d;
    else q = -((-sum + d - 1) / d);
    v = q + longint'($signed(offs));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic predict_pixel(logic cmd, pix_t px_in);
    int len, tot, c;
    pix_t px;
    pix_t colv [3];
    bit emit, done;
    bit [2:0] rok, cok;
    conv_px_t r;
    len = eff_geo(len_reg);
    tot = eff_geo(tot_reg);
    c = in_col % MaxLineLength;
    px = (cmd == 1'b0 && in_ln < tot) ? px_in : '0;
    colv[0] = lines[MaxLineLength + c];
    colv[1] = lines[c];
    colv[2] = px;
    lines[MaxLineLength + c] = colv[1];
    lines[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
      win[k*3+2] = colv[k];
    end
    emit = (in_ln >= 2) || (in_ln == 1 && in_col >= 1);
    if (in_col + 1 >= len) begin
      in_col = 0;
      in_ln++;
    end else in_col++;
    if (emit) begin
      rok = {out_ln + 1 < tot, 1'b1, out_ln != 0};
      cok = {out_col + 1 < len, 1'b1, out_col != 0};
      r.red = conv_chan(16, rok, cok);
      r.green = conv_chan(8, rok, cok);
      r.blue = conv_chan(0, rok, cok);
      done = (out_ln + 1 > tot) || (out_ln + 1 == tot && out_col + 1 >= len);
      r.done = done;
      expected_px_q.push_back(r);
      if (done) begin
        in_ln = 0; in_col = 0; out_ln = 0; out_col = 0;
      end else if (out_col + 1 >= len) begin
        out_col = 0;
        out_ln++;
      end else out_col++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    conv_px_t e;
    if (!rst_ni) begin
      krow[0] = '0; krow[1] = 48'd16777216; krow[2] = '0;
      div_q = 16'd256; offs = '0; len_reg = 11'd1024; tot_reg = 11'd1024;
      for (int k = 0; k < NumTaps; k++) win[k] = '0;
      for (int k = 0; k < 2*MaxLineLength; k++) lines[k] = '0;
      in_ln = 0; in_col = 0; out_ln = 0; out_col = 0;
      fail_count_o = 0;
      expected_px_q.delete();
    end else begin
      // output first: its expectation came from an earlier input beat
      if (out_valid_i && !out_stall_i) begin
        if (expected_px_q.size() == 0) begin
          $error("unexpected output beat");
          fail_count_o++;
        end else begin
          e = expected_px_q.pop_front();
          if (red_out_i !== e.red) begin
            $error("red_out exp %0d got %0d", e.red, red_out_i); fail_count_o++;
          end
          if (green_out_i !== e.green) begin
            $error("green_out exp %0d got %0d", e.green, green_out_i); fail_count_o++;
          end
          if (blue_out_i !== e.blue) begin
            $error("blue_out exp %0d got %0d", e.blue, blue_out_i); fail_count_o++;
          end
          if (frame_done_i !== e.done) begin
            $error("frame_done exp %0d got %0d", e.done, frame_done_i); fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_KROW0:   krow[0] = cfg_data_i;
          CFG_KROW1:   krow[1] = cfg_data_i;
          CFG_KROW2:   krow[2] = cfg_data_i;
          CFG_DIVISOR: div_q = cfg_data_i[15:0];
          CFG_OFFSET:  offs = cfg_data_i[10:0];
          CFG_LINELEN: len_reg = cfg_data_i[10:0];
          CFG_LINETOT: tot_reg = cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        predict_pixel(command_i, {red_in_i, green_in_i, blue_in_i});
    end
  end

endmodule

// ----- verif/tb_rgb_window_convolution_top.sv -----
// Testbench top: drives pixel frames and register settings, reports the verdict.
`timescale 1ns / 1ps
module tb_rgb_window_convolution_top;
  import rgbc_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [2:0]      cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            command_i = 1'b0;
  logic [7:0]      red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [7:0]      red_out_o, green_out_o, blue_out_o;
  logic            frame_done_o;
  int              fail_count, pending, cycle_count;
  bit              calm;

  localparam int CycleLimit = 900000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rgb_window_convolution_top uut (.*);

  rgbc_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .command_i, .red_in_i, .green_in_i,
    .blue_in_i, .out_valid_i(out_valid_o), .out_stall_i, .red_out_i(red_out_o),
    .green_out_i(green_out_o), .blue_out_i(blue_out_o), .frame_done_i(frame_done_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 5);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_beat(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      n = $urandom_range(1, 5);
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    red_in_i <= r; green_in_i <= g; blue_in_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [47:0] rand_row(bit wide);
    logic [47:0] r;
    for (int k = 0; k < 3; k++)
      r[16*k +: 16] = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 1024)) - 512);
    return r;
  endfunction

  // one frame plus trailing flush items to drain it
  task automatic run_frame(int w, int h, int mode);
    int px;
    for (int k = 0; k < w*h; k++) begin
      px = $urandom;
      case (mode)
        0: send_beat(1'b0, px[7:0], px[15:8], px[23:16]);
        1: send_beat(1'b0, 8'hff, 8'hff, 8'hff);
        default: send_beat($urandom_range(0, 9) == 0, px[7:0], px[15:8], px[23:16]);
      endcase
    end
    for (int k = 0; k < w + 1; k++) begin
      px = $urandom;
      // data on a flush or past the last line must be ignored
      send_beat(k[0], px[7:0], px[15:8], px[23:16]);
    end
  endtask

  initial begin
    int w, h, sent;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: smallest frame with identity kernel, then saturated values
    write_reg(CFG_LINELEN, CfgW'(4));
    write_reg(CFG_LINETOT, CfgW'(4));
    run_frame(4, 4, 0);
    run_frame(4, 4, 1);
    idle_drain();

    // extremes: negative and maximum taps, tiny divisor, offset limits, bad geometry
    write_reg(CFG_KROW0, 48'hffff_ffff_ffff);
    write_reg(CFG_KROW1, 48'h8000_7fff_8000);
    write_reg(CFG_KROW2, 48'h7fff_0001_ffff);
    write_reg(CFG_DIVISOR, CfgW'(0));
    write_reg(CFG_OFFSET, CfgW'(11'h400));
    write_reg(CFG_LINELEN, CfgW'(0));
    write_reg(CFG_LINETOT, CfgW'(11'h7ff));
    write_reg(CFG_LINETOT, CfgW'(2));
    run_frame(4, 4, 2);
    idle_drain();
    write_reg(CFG_DIVISOR, CfgW'(16'hffff));
    write_reg(CFG_OFFSET, CfgW'(11'h3ff));
    run_frame(4, 4, 0);
    idle_drain();

    // random phases
    sent = 0;
    while (sent < 330) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(4, 8);
      h = $urandom_range(4, 6);
      write_reg(CFG_KROW0, rand_row($urandom_range(0, 3) == 0));
      write_reg(CFG_KROW1, rand_row($urandom_range(0, 3) == 0));
      write_reg(CFG_KROW2, rand_row($urandom_range(0, 3) == 0));
      write_reg(CFG_DIVISOR, $urandom_range(0, 3) == 0 ? CfgW'(16'($urandom))
                                                      : CfgW'(16'($urandom_range(1, 2048))));
      write_reg(CFG_OFFSET, CfgW'(11'($urandom)));
      write_reg(CFG_LINELEN, CfgW'(w));
      write_reg(CFG_LINETOT, CfgW'(h));
      if (sent > 250) calm = 1'b1;
      run_frame(w, h, 2);
      sent += w*h + w + 1;
      idle_drain();
    end

    // long line for a handful of outputs, reaching deep line store addresses
    write_reg(CFG_LINELEN, CfgW'(200));
    write_reg(CFG_LINETOT, CfgW'(4));
    for (int k = 0; k < 206; k++) send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    idle_drain();

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- rgb_window_convolution_top.f -----
design/rgbc_pkg.sv
design/rgbc_line_ram.sv
design/rgbc_arith.sv
design/rgb_window_convolution_top.sv
verif/rgbc_checker.sv
verif/tb_rgb_window_convolution_top.sv
